@@ design/smooth_window_jet_2d_top_assert.svh @@
// Assertion macros for the smooth window jet block.
`ifndef SMOOTH_WINDOW_JET_2D_TOP_ASSERT_SVH
`define SMOOTH_WINDOW_JET_2D_TOP_ASSERT_SVH
`define SWJ_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define SWJ_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ design/swj_pkg.sv @@
// Package with types, constants and arithmetic helpers of the window jet block.
package swj_pkg;
  localparam int LAT = 21;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam logic signed [31:0] K_PB = 32'sd71680;
  localparam logic signed [31:0] K_SEVENTH = 32'sd9362;
  localparam logic signed [31:0] K_THREE_FIFTHS = 32'sd39322;
  localparam logic signed [31:0] K_PB3 = 32'sd215040;
  localparam logic [1:0] CFG_HALF = 2'd0;
  localparam logic [1:0] CFG_EDGE = 2'd1;
  localparam logic [1:0] CFG_INV = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } in_word_t;

  typedef struct packed {
    logic present;
    logic signed [31:0] c00;
    logic signed [31:0] c10;
    logic signed [31:0] c01;
    logic signed [31:0] c20;
    logic signed [31:0] c11;
    logic signed [31:0] c02;
    logic signed [31:0] c30;
    logic signed [31:0] c21;
    logic signed [31:0] c12;
    logic signed [31:0] c03;
  } out_word_t;

  typedef struct packed {
    logic [30:0] h;
    logic [30:0] e;
    logic [30:0] a;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Round to nearest, ties toward plus infinity, then saturate.
  function automatic logic signed [31:0] rs(input logic signed [63:0] p);
    logic signed [64:0] v;
    v = {p[63], p} + 65'sd32768;
    return sat32({{17{v[64]}}, v[64:16]});
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return rs(64'(a) * 64'(b));
  endfunction
endpackage

@@ design/swj_lane.sv @@
// One coordinate lane: band selection and pipelined septic jet evaluation.
module swj_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  input  logic signed [31:0]  s,
  input  swj_pkg::cfg_t       cfg,
  output logic                out_v,
  output logic signed [31:0]  j0,
  output logic signed [31:0]  j1,
  output logic signed [31:0]  j2,
  output logic signed [31:0]  j3
);
  import swj_pkg::*;

  typedef struct packed {
    logic        zero;
    logic        plat;
    logic        left;
    logic signed [31:0] t;
    logic signed [31:0] t2;
    logic signed [31:0] t4;
    logic signed [31:0] t6;
    logic signed [31:0] p;
    logic signed [31:0] g;
    logic signed [31:0] j1;
    logic signed [31:0] j2;
    logic signed [31:0] j3;
    logic signed [31:0] u;
  } st_t;

  localparam int NS = 19;
  st_t st_r [NS];
  st_t st_nxt [NS];
  logic [NS-1:0] v_r;
  logic signed [31:0] d_r, d_nxt;
  logic signed [63:0] m;
  logic signed [31:0] o0_r, o1_r, o2_r, o3_r;
  logic               ov_r;

  logic signed [33:0] sw, hw, ew;
  logic               zsel, lsel, psel;

  always_comb begin
    sw = 34'(s);
    hw = {3'b000, cfg.h};
    ew = {3'b000, cfg.e};
    zsel = (sw <= -hw - ew) || (sw >= hw + ew);
    lsel = sw < -hw + ew;
    psel = sw < hw - ew;
    d_nxt = sat32(66'(lsel ? sw + hw : sw - hw));
  end

  logic signed [64:0] ad;
  logic signed [32:0] tr;
  logic signed [33:0] tmp;
  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].zero = zsel;
    st_nxt[0].left = !zsel && lsel;
    st_nxt[0].plat = !zsel && !lsel && psel;
    m = $signed({1'b0, cfg.a}) * d_r;
    ad = 65'(m) + 65'sd32768;
    tr = ad[48:16];
    if ($signed(ad[64:16]) > 49'sd65536) tr = 33'sd65536;
    else if ($signed(ad[64:16]) < -49'sd65536) tr = -33'sd65536;
    for (int k = 1; k < NS; k++) st_nxt[k] = st_r[k-1];
    st_nxt[1].t = tr[31:0];
    st_nxt[2].t2 = qmul(st_r[1].t, st_r[1].t);
    st_nxt[3].t4 = qmul(st_r[2].t2, st_r[2].t2);
    st_nxt[4].t6 = qmul(st_r[3].t4, st_r[3].t2);
    st_nxt[5].p = qmul(st_r[4].t6, K_SEVENTH);
    st_nxt[5].u = qmul(st_r[4].t4, K_THREE_FIFTHS);
    tmp = 34'(st_r[5].p) - 34'(st_r[5].u) + 34'(st_r[5].t2) - 34'(ONE_Q);
    st_nxt[6].p = qmul(st_r[5].t, tmp[31:0]);
    st_nxt[7].g = qmul(K_PB, st_r[6].p) + (ONE_Q >>> 1);
    tmp = 34'(st_r[7].t6) - 3 * 34'(st_r[7].t4) + 3 * 34'(st_r[7].t2) - 34'(ONE_Q);
    st_nxt[8].j1 = qmul(K_PB, tmp[31:0]);
    st_nxt[9].j1 = qmul($signed({1'b0, cfg.a}), st_r[8].j1);
    tmp = 34'(st_r[9].t4) - 2 * 34'(st_r[9].t2) + 34'(ONE_Q);
    st_nxt[10].j2 = qmul(st_r[9].t, tmp[31:0]);
    st_nxt[11].j2 = qmul(K_PB3, st_r[10].j2);
    st_nxt[12].j2 = qmul($signed({1'b0, cfg.a}), st_r[11].j2);
    st_nxt[13].j2 = qmul($signed({1'b0, cfg.a}), st_r[12].j2);
    tmp = 5 * 34'(st_r[13].t2) - 34'(6 * 65536);
    st_nxt[14].j3 = qmul(st_r[13].t2, tmp[31:0]) + ONE_Q;
    st_nxt[15].j3 = qmul(K_PB, st_r[14].j3);
    st_nxt[16].j3 = qmul($signed({1'b0, cfg.a}), st_r[15].j3);
    st_nxt[17].j3 = qmul($signed({1'b0, cfg.a}), st_r[16].j3);
    st_nxt[18].j3 = qmul($signed({1'b0, cfg.a}), st_r[17].j3);
  end

  st_t f;
  logic signed [31:0] o0_nxt, o1_nxt, o2_nxt, o3_nxt;
  always_comb begin
    f = st_r[NS-1];
    o0_nxt = '0; o1_nxt = '0; o2_nxt = '0; o3_nxt = '0;
    if (f.zero) begin
      o0_nxt = '0;
    end else if (f.plat) begin
      o0_nxt = ONE_Q;
    end else if (f.left) begin
      o0_nxt = sat32(66'(ONE_Q) - 66'(f.g));
      o1_nxt = sat32(-66'(f.j1));
      o2_nxt = sat32(-66'(f.j2));
      o3_nxt = sat32(-66'(f.j3));
    end else begin
      o0_nxt = f.g; o1_nxt = f.j1; o2_nxt = f.j2; o3_nxt = f.j3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r <= {v_r[NS-2:0], in_v};
      ov_r <= v_r[NS-1];
    end
    d_r <= d_nxt;
    for (int k = 0; k < NS; k++) st_r[k] <= st_nxt[k];
    o0_r <= o0_nxt; o1_r <= o1_nxt; o2_r <= o2_nxt; o3_r <= o3_nxt;
  end

  assign out_v = ov_r;
  assign j0 = o0_r;
  assign j1 = o1_r;
  assign j2 = o2_r;
  assign j3 = o3_r;
endmodule

@@ design/swj_merge.sv @@
// Merge stage: tensor products of the two lane jets and the present flag.
module swj_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  logic signed [31:0] jx [4],
  input  logic signed [31:0] jy [4],
  output logic               out_v,
  output swj_pkg::out_word_t res
);
  import swj_pkg::*;

  out_word_t r_r, r_nxt;
  logic v_r;
  logic pr;

  always_comb begin
    pr = (jx[0] != 0) && (jy[0] != 0);
    r_nxt.present = pr;
    r_nxt.c00 = pr ? qmul(jx[0], jy[0]) : '0;
    r_nxt.c10 = pr ? qmul(jx[1], jy[0]) : '0;
    r_nxt.c01 = pr ? qmul(jx[0], jy[1]) : '0;
    r_nxt.c20 = pr ? qmul(jx[2], jy[0]) : '0;
    r_nxt.c11 = pr ? qmul(jx[1], jy[1]) : '0;
    r_nxt.c02 = pr ? qmul(jx[0], jy[2]) : '0;
    r_nxt.c30 = pr ? qmul(jx[3], jy[0]) : '0;
    r_nxt.c21 = pr ? qmul(jx[2], jy[1]) : '0;
    r_nxt.c12 = pr ? qmul(jx[1], jy[2]) : '0;
    r_nxt.c03 = pr ? qmul(jx[0], jy[3]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= in_v;
    r_r <= r_nxt;
  end

  assign out_v = v_r;
  assign res = r_r;
endmodule

@@ design/smooth_window_jet_2d_top.sv @@
// Top level of the two-dimensional septic smooth window jet block.
//   channel | signals                         | transfer
//   input   | start, busy, in_word            | start && !busy
//   result  | out_valid, out_word            | out_valid
//   config  | cfg_we, cfg_index, cfg_data     | cfg_we
// One point is taken every cycle; busy is never high after reset.
// A result is registered through the lane pipeline of chained fixed-point multiplies
// and then through the merge stage before it is on the output.
// Reset is synchronous and restores the register defaults.
// The receiver cannot stall; results are shown for one cycle only.
module smooth_window_jet_2d_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swj_pkg::in_word_t   in_word,
  output logic                out_valid,
  output swj_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import swj_pkg::*;

  cfg_t cfg_r;
  logic acc;
  logic vx, vy;
  logic signed [31:0] jx [4];
  logic signed [31:0] jy [4];

  assign busy = 1'b0;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h <= 31'd65536;
      cfg_r.e <= 31'd16384;
      cfg_r.a <= 31'd262144;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF: cfg_r.h <= cfg_data;
        CFG_EDGE: cfg_r.e <= cfg_data;
        CFG_INV:  cfg_r.a <= cfg_data;
        default: ;
      endcase
    end
  end

  swj_lane u_lx (.clk, .rst_n, .in_v(acc), .s(in_word.x), .cfg(cfg_r),
    .out_v(vx), .j0(jx[0]), .j1(jx[1]), .j2(jx[2]), .j3(jx[3]));
  swj_lane u_ly (.clk, .rst_n, .in_v(acc), .s(in_word.y), .cfg(cfg_r),
    .out_v(vy), .j0(jy[0]), .j1(jy[1]), .j2(jy[2]), .j3(jy[3]));

  swj_merge u_mg (.clk, .rst_n, .in_v(vx && vy), .jx(jx), .jy(jy),
    .out_v(out_valid), .res(out_word));
endmodule

@@ design/swj_checker.sv @@
// Port checker for the window jet block and its bind.
`include "smooth_window_jet_2d_top_assert.svh"
module swj_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input swj_pkg::out_word_t out_word
);
  import swj_pkg::*;
  `SWJ_ASSERT_IMP(a_nobusy, clk, rst_n, 1'b1, !busy)
  `SWJ_ASSERT_IMP(a_abs, clk, rst_n, out_valid && !out_word.present, out_word.c00 == 0 && out_word.c11 == 0)
  `SWJ_ASSERT_IMP(a_pres, clk, rst_n, out_valid && out_word.present, out_word.c00 != 32'sh80000000)
  `SWJ_ASSERT_NXT(a_idle, clk, rst_n, !start, 1'b1)
endmodule

bind smooth_window_jet_2d_top swj_checker u_chk (.clk, .rst_n, .start, .busy,
  .out_valid, .out_word);
